// File: src/lidu_pkg.sv
// Shared types, constants and the instruction pattern table of the decoder.
// No dependencies.
`timescale 1ns / 1ps
package lidu_pkg;

    typedef enum logic [4:0] {
        FMT_NO = 5'd0, FMT_R = 5'd1, FMT_O = 5'd2, FMT_RO = 5'd3, FMT_OR = 5'd4,
        FMT_AF = 5'd5, FMT_OO = 5'd6, FMT_D = 5'd7, FMT_RD = 5'd8, FMT_I8 = 5'd9,
        FMT_I6 = 5'd10, FMT_I3 = 5'd11, FMT_IL = 5'd12, FMT_FA = 5'd13, FMT_F = 5'd14,
        FMT_AO = 5'd15, FMT_OA = 5'd16
    } fmt_t;

    typedef enum logic [3:0] {
        X_NO = 4'd0, X_BA = 4'd1, X_CSM = 4'd2, X_CIS = 4'd3, X_EIS = 4'd4,
        X_FIS = 4'd5, X_FPP = 4'd6, X_LE = 4'd7, X_MFPT = 4'd8, X_MP = 4'd9,
        X_MX = 4'd10, X_SPL = 4'd11, X_UC = 4'd12
    } ext_t;

    typedef struct packed {
        logic [7:0] index;
        fmt_t       fmt;
        ext_t       ext;
    } match_t;

    localparam logic [15:0] M_ALL = 16'o177777;
    localparam logic [15:0] M_OP  = 16'o177700;
    localparam logic [15:0] M_DO  = 16'o170000;
    localparam logic [15:0] M_BR  = 16'o177400;
    localparam logic [15:0] M_RO  = 16'o177000;
    localparam logic [15:0] M_R   = 16'o177770;

    // Priority lookup: first matching row wins, the final row catches all.
    function automatic match_t lookup(input logic [15:0] w);
        match_t r;
        logic [15:0] w6;
        logic [15:0] w3;
        logic [15:0] w8;
        logic [15:0] w9;
        logic [15:0] w12;
        w6  = w & M_OP;
        w3  = w & M_R;
        w8  = w & M_BR;
        w9  = w & M_RO;
        w12 = w & M_DO;
        r = '{index: 8'd202, fmt: FMT_IL, ext: X_NO};
        if (w <= 16'o7)
            r = '{index: w[7:0], fmt: FMT_NO,
                  ext: (w == 16'o6) ? X_LE : ((w == 16'o7) ? X_MFPT : X_BA)};
        else if (w6 == 16'o100) r = '{8'd8, FMT_O, X_BA};
        else if (w3 == 16'o200) r = '{8'd9, FMT_R, X_BA};
        else if (w3 == 16'o210) r = '{8'd10, FMT_IL, X_NO};
        else if (w3 == 16'o220) r = '{8'd11, FMT_IL, X_NO};
        else if (w3 == 16'o230) r = '{8'd12, FMT_I3, X_SPL};
        else if (w >= 16'o240 && w <= 16'o277)
            r = '{8'(w - 16'o240 + 16'd13), FMT_NO, X_BA};
        else if (w6 == 16'o300) r = '{8'd45, FMT_O, X_BA};
        else if (w8 >= 16'o400 && w8 <= 16'o3400)
            r = '{8'(16'd45 + (w8 >> 8)), FMT_D, X_BA};
        else if (w9 == 16'o4000) r = '{8'd53, FMT_RO, X_BA};
        else if (w6 >= 16'o5000 && w6 <= 16'o7200) begin
            r = '{8'(16'd54 + ((w6 - 16'o5000) >> 6)), FMT_O, X_BA};
            if (w6 == 16'o6400) r.fmt = FMT_I6;
            if (w6 == 16'o6400 || w6 == 16'o6700) r.ext = X_LE;
            if (w6 == 16'o7000) r.ext = X_CSM;
            if (w6 == 16'o7100 || w6 == 16'o7200) r.ext = X_MP;
        end
        else if (w12 >= 16'o10000 && w12 <= 16'o60000)
            r = '{8'(16'd72 + (w12 >> 12)), FMT_OO, X_BA};
        else if (w9 >= 16'o70000 && w9 <= 16'o73000)
            r = '{8'(16'd79 + ((w9 >> 9) & 16'd7)), FMT_OR, X_EIS};
        else if (w9 == 16'o74000) r = '{8'd83, FMT_RO, X_LE};
        else if (w3 >= 16'o75000 && w3 <= 16'o75030)
            r = '{8'(16'd84 + ((w3 >> 3) & 16'd3)), FMT_R, X_FIS};
        else if (w3 == 16'o76020) r = '{8'd88, FMT_R, X_CIS};
        else if (w >= 16'o76030 && w <= 16'o76032)
            r = '{8'(16'd89 + (w & 16'd3)), FMT_NO, X_CIS};
        else if (w >= 16'o76040 && w <= 16'o76045)
            r = '{8'(16'd92 + (w & 16'd7)), FMT_NO, X_CIS};
        else if (w >= 16'o76050 && w <= 16'o76057)
            r = '{8'(16'd98 + (w & 16'd7)), FMT_NO, X_CIS};
        else if (w3 == 16'o76060) r = '{8'd106, FMT_R, X_CIS};
        else if (w >= 16'o76070 && w <= 16'o76077)
            r = '{8'(16'd107 + (w & 16'd7)), FMT_NO, X_CIS};
        else if (w >= 16'o76130 && w <= 16'o76132)
            r = '{8'(16'd115 + (w & 16'd3)), FMT_NO, X_CIS};
        else if (w >= 16'o76140 && w <= 16'o76145)
            r = '{8'(16'd118 + (w & 16'd7)), FMT_NO, X_CIS};
        else if (w >= 16'o76150 && w <= 16'o76157)
            r = '{8'(16'd124 + (w & 16'd7)), FMT_NO, X_CIS};
        else if (w >= 16'o76170 && w <= 16'o76177)
            r = '{8'(16'd132 + (w & 16'd7)), FMT_NO, X_CIS};
        else if (w == 16'o76600) r = '{8'd140, FMT_NO, X_UC};
        else if (w6 == 16'o76700) r = '{8'd141, FMT_I6, X_UC};
        else if (w9 == 16'o77000) r = '{8'd142, FMT_RD, X_LE};
        else if (w8 >= 16'o100000 && w8 <= 16'o103400)
            r = '{8'(16'd143 + ((w8 >> 8) & 16'd7)), FMT_D, X_BA};
        else if (w8 == 16'o104000 || w8 == 16'o104400)
            r = '{8'(16'd151 + ((w8 >> 8) & 16'd1)), FMT_I8, X_BA};
        else if (w6 >= 16'o105000 && w6 <= 16'o106700) begin
            r = '{8'(16'd153 + ((w6 - 16'o105000) >> 6)), FMT_O, X_BA};
            if (w6 == 16'o106400 || w6 == 16'o106700) r.ext = X_MX;
        end
        else if (w12 >= 16'o110000 && w12 <= 16'o160000)
            r = '{8'(16'd168 + ((w12 >> 12) & 16'd7)), FMT_OO, X_BA};
        else if (w == 16'o170000 || w == 16'o170001 || w == 16'o170002)
            r = '{8'(16'd175 + (w & 16'd3)), FMT_NO, X_FPP};
        else if (w == 16'o170003) r = '{8'd178, FMT_NO, X_UC};
        else if (w == 16'o170011) r = '{8'd179, FMT_NO, X_FPP};
        else if (w == 16'o170012) r = '{8'd180, FMT_NO, X_FPP};
        else if (w6 >= 16'o170100 && w6 <= 16'o170700)
            r = '{8'(16'd180 + ((w6 >> 6) & 16'd7)),
                  (w6 >= 16'o170400) ? FMT_F : FMT_O, X_FPP};
        else if (w8 >= 16'o171000) begin
            r = '{8'(16'd188 + ((w8 - 16'o171000) >> 8)), FMT_FA, X_FPP};
            case (w8)
                16'o174000, 16'o176000: r.fmt = FMT_AF;
                16'o175000, 16'o175400: r.fmt = FMT_AO;
                16'o176400, 16'o177000: r.fmt = FMT_OA;
                default:                r.fmt = FMT_FA;
            endcase
        end
        return r;
    endfunction

endpackage

// File: src/lidu_core.sv
// Combinational decode of one registered instruction beat.
// Depends on lidu_pkg.
`timescale 1ns / 1ps
module lidu_core (
    input  logic [15:0]  instr_addr,
    input  logic [15:0]  instr_word,
    input  logic [15:0]  src_ext_word,
    input  logic [15:0]  dst_ext_word,
    output logic [7:0]   mnemonic_index,
    output logic [4:0]   operand_format,
    output logic [1:0]   word_count,
    output logic [5:0]   src_spec,
    output logic [5:0]   dst_spec,
    output logic [1:0]   fpu_accumulator,
    output logic [7:0]   immediate_value,
    output logic [15:0]  branch_target,
    output logic [15:0]  src_rel_address,
    output logic [15:0]  dst_rel_address,
    output logic [3:0]   isa_extension
);
    import lidu_pkg::*;

    match_t m;
    fmt_t   f;
    logic   has_dst;
    logic   src_ext;
    logic   dst_ext;
    logic   src_pc;
    logic   dst_pc;
    logic [1:0] words;

    // Look up the row and derive the operand extension words
    always_comb
    begin
        m = lookup(instr_word);
        f = m.fmt;
        src_spec = instr_word[11:6];
        dst_spec = instr_word[5:0];
        has_dst = (f == FMT_O) || (f == FMT_RO) || (f == FMT_OR) || (f == FMT_AF) ||
                  (f == FMT_OO) || (f == FMT_FA) || (f == FMT_F) || (f == FMT_AO) ||
                  (f == FMT_OA);
        src_ext = (f == FMT_OO) && (instr_word[11:10] == 2'b11 ||
                  (instr_word[11:10] == 2'b01 && instr_word[8:6] == 3'd7));
        src_pc  = (f == FMT_OO) && instr_word[11:10] == 2'b11 && instr_word[8:6] == 3'd7;
        dst_ext = has_dst && (instr_word[5:4] == 2'b11 ||
                  (instr_word[5:4] == 2'b01 && instr_word[2:0] == 3'd7));
        dst_pc  = has_dst && instr_word[5:4] == 2'b11 && instr_word[2:0] == 3'd7;
        words = 2'd1 + {1'b0, src_ext} + {1'b0, dst_ext};
        word_count = words;
        mnemonic_index = m.index;
        operand_format = f;
        isa_extension = m.ext;
        src_rel_address = src_pc ? instr_addr + 16'd4 + src_ext_word : 16'd0;
        dst_rel_address = dst_pc ? instr_addr + {13'd0, words, 1'b0} + dst_ext_word : 16'd0;
        fpu_accumulator = (f == FMT_AF || f == FMT_FA || f == FMT_AO || f == FMT_OA)
                          ? instr_word[7:6] : 2'd0;
        case (f)
            FMT_I8:  immediate_value = instr_word[7:0];
            FMT_I6:  immediate_value = {2'd0, instr_word[5:0]};
            FMT_I3:  immediate_value = {5'd0, instr_word[2:0]};
            default: immediate_value = 8'd0;
        endcase
        case (f)
            FMT_D:   branch_target = instr_addr + 16'd2 +
                                     {{7{instr_word[7]}}, instr_word[7:0], 1'b0};
            FMT_RD:  branch_target = instr_addr + 16'd2 - {9'd0, instr_word[5:0], 1'b0};
            default: branch_target = 16'd0;
        endcase
    end

endmodule

// File: src/legacy_isa_instruction_decoder_unit.sv
// Top level: input register, decode logic and output register with stall.
// Depends on lidu_pkg and lidu_core.
`timescale 1ns / 1ps
// One instruction beat is accepted per cycle while in_stall is low; its decode
// passes through the input register, then the result register, to the
// output, and out_stall can hold it there. Rate is set by the combinational
// table lookup and address adders between the two registers. The block is
// stateless apart from its pipeline registers and their valid bits.
module legacy_isa_instruction_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] instr_addr,
    input  logic [15:0] instr_word,
    input  logic [15:0] src_ext_word,
    input  logic [15:0] dst_ext_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  mnemonic_index,
    output logic [4:0]  operand_format,
    output logic [1:0]  word_count,
    output logic [5:0]  src_spec,
    output logic [5:0]  dst_spec,
    output logic [1:0]  fpu_accumulator,
    output logic [7:0]  immediate_value,
    output logic [15:0] branch_target,
    output logic [15:0] src_rel_address,
    output logic [15:0] dst_rel_address,
    output logic [3:0]  isa_extension
);
    import lidu_pkg::*;

    logic        v1_reg;
    logic [15:0] a_reg, w_reg, s_reg, d_reg;
    logic        v2_reg;
    logic        adv2;
    logic        adv1;

    logic [7:0]  c_idx;
    logic [4:0]  c_fmt;
    logic [1:0]  c_wc;
    logic [5:0]  c_ss, c_ds;
    logic [1:0]  c_ac;
    logic [7:0]  c_imm;
    logic [15:0] c_br, c_sr, c_dr;
    logic [3:0]  c_ext;

    // Advance when the stage ahead is empty or draining
    assign adv2 = !v2_reg || !out_stall;
    assign adv1 = !v1_reg || adv2;
    assign in_stall = !adv1;
    assign out_valid = v2_reg;

    // Hold the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv1)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            a_reg <= instr_addr;
            w_reg <= instr_word;
            s_reg <= src_ext_word;
            d_reg <= dst_ext_word;
        end
    end

    lidu_core u_core (
        .instr_addr(a_reg), .instr_word(w_reg), .src_ext_word(s_reg),
        .dst_ext_word(d_reg), .mnemonic_index(c_idx), .operand_format(c_fmt),
        .word_count(c_wc), .src_spec(c_ss), .dst_spec(c_ds), .fpu_accumulator(c_ac),
        .immediate_value(c_imm), .branch_target(c_br), .src_rel_address(c_sr),
        .dst_rel_address(c_dr), .isa_extension(c_ext)
    );

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            mnemonic_index  <= c_idx;
            operand_format  <= c_fmt;
            word_count      <= c_wc;
            src_spec        <= c_ss;
            dst_spec        <= c_ds;
            fpu_accumulator <= c_ac;
            immediate_value <= c_imm;
            branch_target   <= c_br;
            src_rel_address <= c_sr;
            dst_rel_address <= c_dr;
            isa_extension   <= c_ext;
        end
    end

endmodule

// File: tb/legacy_isa_instruction_decoder_unit_tb.sv
// Testbench for the instruction decoder: queue-fed driver, clocked monitor, decode predictor.
// Depends on lidu_pkg and legacy_isa_instruction_decoder_unit.
`timescale 1ns / 1ps
module legacy_isa_instruction_decoder_unit_tb;
    import lidu_pkg::*;

    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] word;
        logic [15:0] sx;
        logic [15:0] dx;
    } instr_beat_t;

    typedef struct packed {
        logic [7:0]  index;
        logic [4:0]  fmt;
        logic [1:0]  words;
        logic [5:0]  src;
        logic [5:0]  dst;
        logic [1:0]  ac;
        logic [7:0]  imm;
        logic [15:0] br;
        logic [15:0] srel;
        logic [15:0] drel;
        logic [3:0]  ext;
    } decode_t;

    typedef struct {
        logic [15:0] pat;
        logic [15:0] msk;
        fmt_t        fmt;
        ext_t        ext;
    } op_row_t;

    localparam int LIMIT_CYCLES = 200000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] instr_addr;
    logic [15:0] instr_word;
    logic [15:0] src_ext_word;
    logic [15:0] dst_ext_word;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  mnemonic_index;
    logic [4:0]  operand_format;
    logic [1:0]  word_count;
    logic [5:0]  src_spec;
    logic [5:0]  dst_spec;
    logic [1:0]  fpu_accumulator;
    logic [7:0]  immediate_value;
    logic [15:0] branch_target;
    logic [15:0] src_rel_address;
    logic [15:0] dst_rel_address;
    logic [3:0]  isa_extension;

    op_row_t     op_rows[$];
    instr_beat_t pending_beats[$];
    decode_t     expected_decodes[$];
    int          mismatches;
    int          beats_sent;
    int          decodes_seen;
    int          cycles;
    bit          stim_done;
    int          burst_left;
    int          gap_left;
    int          stall_phase;
    int          stall_mode;

    legacy_isa_instruction_decoder_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .instr_addr(instr_addr), .instr_word(instr_word),
        .src_ext_word(src_ext_word), .dst_ext_word(dst_ext_word),
        .out_valid(out_valid), .out_stall(out_stall),
        .mnemonic_index(mnemonic_index), .operand_format(operand_format),
        .word_count(word_count), .src_spec(src_spec), .dst_spec(dst_spec),
        .fpu_accumulator(fpu_accumulator), .immediate_value(immediate_value),
        .branch_target(branch_target), .src_rel_address(src_rel_address),
        .dst_rel_address(dst_rel_address), .isa_extension(isa_extension)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic add_row(input logic [15:0] p, input logic [15:0] m,
                           input fmt_t f, input ext_t x);
        op_row_t r;
        r.pat = p;
        r.msk = m;
        r.fmt = f;
        r.ext = x;
        op_rows.push_back(r);
    endtask

    task automatic add_run(input logic [15:0] first, input logic [15:0] last,
                           input logic [15:0] m, input logic [15:0] step,
                           input fmt_t f, input ext_t x);
        logic [16:0] p;
        for (p = {1'b0, first}; p <= {1'b0, last}; p = p + step)
            add_row(p[15:0], m, f, x);
    endtask

    // Build the opcode pattern table in match order; last row catches all.
    task automatic build_op_rows();
        add_run(16'o0, 16'o5, M_ALL, 1, FMT_NO, X_BA);
        add_row(16'o6, M_ALL, FMT_NO, X_LE);
        add_row(16'o7, M_ALL, FMT_NO, X_MFPT);
        add_row(16'o100, M_OP, FMT_O, X_BA);
        add_row(16'o200, M_R, FMT_R, X_BA);
        add_row(16'o210, M_R, FMT_IL, X_NO);
        add_row(16'o220, M_R, FMT_IL, X_NO);
        add_row(16'o230, M_R, FMT_I3, X_SPL);
        add_run(16'o240, 16'o277, M_ALL, 1, FMT_NO, X_BA);
        add_row(16'o300, M_OP, FMT_O, X_BA);
        add_run(16'o400, 16'o3400, M_BR, 16'o400, FMT_D, X_BA);
        add_row(16'o4000, M_RO, FMT_RO, X_BA);
        add_run(16'o5000, 16'o6300, M_OP, 16'o100, FMT_O, X_BA);
        add_row(16'o6400, M_OP, FMT_I6, X_LE);
        add_row(16'o6500, M_OP, FMT_O, X_BA);
        add_row(16'o6600, M_OP, FMT_O, X_BA);
        add_row(16'o6700, M_OP, FMT_O, X_LE);
        add_row(16'o7000, M_OP, FMT_O, X_CSM);
        add_row(16'o7100, M_OP, FMT_O, X_MP);
        add_row(16'o7200, M_OP, FMT_O, X_MP);
        add_run(16'o10000, 16'o60000, M_DO, 16'o10000, FMT_OO, X_BA);
        add_run(16'o70000, 16'o73000, M_RO, 16'o1000, FMT_OR, X_EIS);
        add_row(16'o74000, M_RO, FMT_RO, X_LE);
        add_run(16'o75000, 16'o75030, M_R, 16'o10, FMT_R, X_FIS);
        add_row(16'o76020, M_R, FMT_R, X_CIS);
        add_run(16'o76030, 16'o76032, M_ALL, 1, FMT_NO, X_CIS);
        add_run(16'o76040, 16'o76045, M_ALL, 1, FMT_NO, X_CIS);
        add_run(16'o76050, 16'o76057, M_ALL, 1, FMT_NO, X_CIS);
        add_row(16'o76060, M_R, FMT_R, X_CIS);
        add_run(16'o76070, 16'o76077, M_ALL, 1, FMT_NO, X_CIS);
        add_run(16'o76130, 16'o76132, M_ALL, 1, FMT_NO, X_CIS);
        add_run(16'o76140, 16'o76145, M_ALL, 1, FMT_NO, X_CIS);
        add_run(16'o76150, 16'o76157, M_ALL, 1, FMT_NO, X_CIS);
        add_run(16'o76170, 16'o76177, M_ALL, 1, FMT_NO, X_CIS);
        add_row(16'o76600, M_ALL, FMT_NO, X_UC);
        add_row(16'o76700, M_OP, FMT_I6, X_UC);
        add_row(16'o77000, M_RO, FMT_RD, X_LE);
        add_run(16'o100000, 16'o103400, M_BR, 16'o400, FMT_D, X_BA);
        add_row(16'o104000, M_BR, FMT_I8, X_BA);
        add_row(16'o104400, M_BR, FMT_I8, X_BA);
        add_run(16'o105000, 16'o106300, M_OP, 16'o100, FMT_O, X_BA);
        add_row(16'o106400, M_OP, FMT_O, X_MX);
        add_row(16'o106500, M_OP, FMT_O, X_BA);
        add_row(16'o106600, M_OP, FMT_O, X_BA);
        add_row(16'o106700, M_OP, FMT_O, X_MX);
        add_run(16'o110000, 16'o160000, M_DO, 16'o10000, FMT_OO, X_BA);
        add_run(16'o170000, 16'o170002, M_ALL, 1, FMT_NO, X_FPP);
        add_row(16'o170003, M_ALL, FMT_NO, X_UC);
        add_row(16'o170011, M_ALL, FMT_NO, X_FPP);
        add_row(16'o170012, M_ALL, FMT_NO, X_FPP);
        add_run(16'o170100, 16'o170300, M_OP, 16'o100, FMT_O, X_FPP);
        add_run(16'o170400, 16'o170700, M_OP, 16'o100, FMT_F, X_FPP);
        add_run(16'o171000, 16'o173400, M_BR, 16'o400, FMT_FA, X_FPP);
        add_row(16'o174000, M_BR, FMT_AF, X_FPP);
        add_row(16'o174400, M_BR, FMT_FA, X_FPP);
        add_row(16'o175000, M_BR, FMT_AO, X_FPP);
        add_row(16'o175400, M_BR, FMT_AO, X_FPP);
        add_row(16'o176000, M_BR, FMT_AF, X_FPP);
        add_row(16'o176400, M_BR, FMT_OA, X_FPP);
        add_row(16'o177000, M_BR, FMT_OA, X_FPP);
        add_row(16'o177400, M_BR, FMT_FA, X_FPP);
        add_row(16'o0, 16'o0, FMT_IL, X_NO);
    endtask

    function automatic bit needs_ext_word(input logic [5:0] spec);
        return (spec[5:4] == 2'b11) || (spec[5:4] == 2'b01 && spec[2:0] == 3'd7);
    endfunction

    function automatic bit is_pc_rel(input logic [5:0] spec);
        return spec[5:4] == 2'b11 && spec[2:0] == 3'd7;
    endfunction

    // Decode one instruction beat the way the block should.
    function automatic decode_t decode_instr(input instr_beat_t b);
        decode_t d;
        int      i;
        fmt_t    f;
        bit      has_dst;
        logic [15:0] off;
        for (i = 0; i < op_rows.size() - 1; i++)
            if ((b.word & op_rows[i].msk) == op_rows[i].pat) break;
        f = op_rows[i].fmt;
        d = '0;
        d.index = i[7:0];
        d.fmt = f;
        d.ext = op_rows[i].ext;
        d.src = b.word[11:6];
        d.dst = b.word[5:0];
        d.words = 2'd1;
        has_dst = f inside {FMT_O, FMT_RO, FMT_OR, FMT_AF, FMT_OO, FMT_FA, FMT_F,
                            FMT_AO, FMT_OA};
        if (f == FMT_OO && needs_ext_word(d.src))
        begin
            d.words = d.words + 2'd1;
            if (is_pc_rel(d.src)) d.srel = b.addr + 16'd4 + b.sx;
        end
        if (has_dst && needs_ext_word(d.dst)) d.words = d.words + 2'd1;
        if (has_dst && is_pc_rel(d.dst)) d.drel = b.addr + {13'd0, d.words, 1'b0} + b.dx;
        if (f inside {FMT_AF, FMT_FA, FMT_AO, FMT_OA}) d.ac = b.word[7:6];
        if (f == FMT_I8) d.imm = b.word[7:0];
        else if (f == FMT_I6) d.imm = {2'b00, b.word[5:0]};
        else if (f == FMT_I3) d.imm = {5'd0, b.word[2:0]};
        if (f == FMT_D)
        begin
            off = {{8{b.word[7]}}, b.word[7:0]};
            d.br = b.addr + 16'd2 + (off << 1);
        end
        else if (f == FMT_RD)
            d.br = b.addr + 16'd2 - {9'd0, b.word[5:0], 1'b0};
        return d;
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom);
    endfunction

    function automatic logic [5:0] rand_spec();
        // Favor the pc register.
        logic [5:0] s;
        s = 6'($urandom);
        if ($urandom_range(0, 2) == 0) s[2:0] = 3'd7;
        return s;
    endfunction

    task automatic queue_beat(input logic [15:0] a, input logic [15:0] w,
                              input logic [15:0] s, input logic [15:0] x);
        instr_beat_t b;
        b.addr = a;
        b.word = w;
        b.sx = s;
        b.dx = x;
        pending_beats.push_back(b);
    endtask

    // Fill the stimulus queue: directed corners, then random beats, mostly table-driven.
    initial
    begin
        int          n;
        int          r;
        logic [15:0] w;
        build_op_rows();
        queue_beat(16'h0000, 16'o000000, 16'h0000, 16'h0000);
        queue_beat(16'hffff, 16'o177777, 16'hffff, 16'hffff);
        queue_beat(16'hfffe, 16'o000777, 16'h1234, 16'h0000);
        queue_beat(16'h0000, 16'o000400, 16'h0000, 16'h0000);
        queue_beat(16'h0000, 16'o077077, 16'h0000, 16'h0000);
        queue_beat(16'hfffe, 16'o077000, 16'h0000, 16'h0000);
        queue_beat(16'h1000, 16'o016767, 16'hfff0, 16'h0010);
        queue_beat(16'hfffc, 16'o017777, 16'hffff, 16'hffff);
        queue_beat(16'h2000, 16'o012727, 16'h0001, 16'h0002);
        queue_beat(16'h2000, 16'o005067, 16'h0000, 16'h8000);
        queue_beat(16'h0100, 16'o000261, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o000210, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o000237, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o104377, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o006477, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o076777, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o174367, 16'h0000, 16'h4000);
        queue_beat(16'h0100, 16'o177767, 16'h0000, 16'h0004);
        queue_beat(16'h0100, 16'o176477, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o170777, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o076033, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o170004, 16'h0000, 16'h0000);
        queue_beat(16'h0100, 16'o070767, 16'h0000, 16'h0006);
        for (n = 0; n < 1700; n++)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                // Pick a table row and fill its don't-care bits at random.
                r = $urandom_range(0, op_rows.size() - 2);
                w = op_rows[r].pat | (rand16() & ~op_rows[r].msk);
                if ($urandom_range(0, 1) == 0 && op_rows[r].msk[5:0] == 6'd0)
                    w[5:0] = rand_spec();
                if ($urandom_range(0, 1) == 0 && op_rows[r].msk[11:6] == 6'd0)
                    w[11:6] = rand_spec();
            end
            else
                w = rand16();
            queue_beat(rand16(), w, rand16(), rand16());
        end
    end

    // Reset once, then let the driver run until the queue is empty.
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Drive beats in bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            instr_addr <= '0;
            instr_word <= '0;
            src_ext_word <= '0;
            dst_ext_word <= '0;
            burst_left <= 0;
            gap_left <= 0;
            beats_sent <= 0;
            stim_done <= 1'b0;
        end
        else if (!(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                expected_decodes.push_back(decode_instr({instr_addr, instr_word,
                                                         src_ext_word, dst_ext_word}));
                beats_sent <= beats_sent + 1;
            end
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_beats.size() > 0)
            begin
                instr_beat_t b;
                b = pending_beats.pop_front();
                in_valid <= 1'b1;
                instr_addr <= b.addr;
                instr_word <= b.word;
                src_ext_word <= b.sx;
                dst_ext_word <= b.dx;
                if (burst_left > 0) burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                in_valid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
    end

    // Stall the output on a pattern whose mode is redrawn at random at regular intervals.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase <= 0;
            stall_mode <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (stall_phase % 300 == 299) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= (stall_phase % 7) < 3;
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // Compare each accepted decode against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            decode_t got;
            decode_t want;
            got = {mnemonic_index, operand_format, word_count, src_spec, dst_spec,
                   fpu_accumulator, immediate_value, branch_target, src_rel_address,
                   dst_rel_address, isa_extension};
            decodes_seen = decodes_seen + 1;
            if (expected_decodes.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10) $display("ERROR: unexpected decode beat %h", got);
            end
            else
            begin
                want = expected_decodes.pop_front();
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("ERROR: decode %0d: expected %h got %h",
                                 decodes_seen, want, got);
                end
            end
        end
    end

    // Wait for the last decode, drain, then report.
    initial
    begin
        mismatches = 0;
        decodes_seen = 0;
        cycles = 0;
        wait (rst_n === 1'b1);
        while (!(stim_done && expected_decodes.size() == 0) && cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles = cycles + 1;
        end
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            repeat (20) @(posedge clk);
            if (expected_decodes.size() != 0) mismatches = mismatches + 1;
            $display("Decoded %0d instruction beats, %0d checked, %0d mismatches.",
                     beats_sent, decodes_seen, mismatches);
            if (mismatches == 0)
                $display("Test completed successfully");
            else
                $display("Test completed with failures");
            $finish;
        end
    end

endmodule
